FILE: hw/rtl/nec_ir_frame_decoder_core_defines.svh
// ---------------------------------------------------------------------------
// NEC IR frame decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_CORE_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_CORE_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define NIRFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define NIRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nirfd_pkg.sv
// ---------------------------------------------------------------------------
// NEC IR frame decoder package
// Widths, register codes, frame constants and the symbol class entry.
// ---------------------------------------------------------------------------
package nirfd_pkg;

  localparam int DUR_W       = 15;
  localparam int CODE_W      = 32;
  localparam int COUNT_W     = 7;
  localparam int TOL_W       = 12;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_REGS    = 8;

  localparam int DEF_TOLERANCE     = 120;
  localparam int DEF_CAPTURE_DEPTH = 64;

  localparam int FRAME_SYMBOLS = 34;
  localparam int FOOTER_INDEX  = 33;
  localparam int MIN_SYMBOLS   = 11;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HDR_MARK  = 4'd0,
    REG_HDR_SPACE = 4'd1,
    REG_ONE_MARK  = 4'd2,
    REG_ONE_SPACE = 4'd3,
    REG_ZRO_MARK  = 4'd4,
    REG_ZRO_SPACE = 4'd5,
    REG_FTR_MARK  = 4'd6,
    REG_FTR_SPACE = 4'd7
  } cfg_reg_e;

  // Match flags of one symbol against every target pair, and its capture-end flag.
  typedef struct packed {
    logic hdr_ok;
    logic one_ok;
    logic zero_ok;
    logic ftr_ok;
    logic last;
  } sym_class_t;

  function automatic logic [DUR_W-1:0] cfg_reset_value(input int idx);
    logic [DUR_W-1:0] v;
    case (idx)
      REG_HDR_MARK:  v = DUR_W'(9000);
      REG_HDR_SPACE: v = DUR_W'(4500);
      REG_ONE_MARK:  v = DUR_W'(560);
      REG_ONE_SPACE: v = DUR_W'(1690);
      REG_ZRO_MARK:  v = DUR_W'(560);
      REG_ZRO_SPACE: v = DUR_W'(560);
      REG_FTR_MARK:  v = DUR_W'(560);
      default:       v = '0;
    endcase
    return v;
  endfunction

  // t - tol < d < t + tol, with no lower bound when t < tol.
  function automatic logic near_target(input logic [DUR_W-1:0] d,
                                       input logic [DUR_W-1:0] t,
                                       input logic [TOL_W-1:0] tol);
    logic [DUR_W+1:0] d_x;
    logic [DUR_W+1:0] t_x;
    logic [DUR_W+1:0] tol_x;
    d_x   = {2'b00, d};
    t_x   = {2'b00, t};
    tol_x = (DUR_W+2)'(tol);
    return (d_x < t_x + tol_x) && (d_x + tol_x > t_x);
  endfunction

endpackage

FILE: hw/rtl/nirfd_queue.sv
// ---------------------------------------------------------------------------
// NEC IR frame decoder class queue
// Two-entry queue of classified symbols between front and back.
// ---------------------------------------------------------------------------
`include "nec_ir_frame_decoder_core_defines.svh"

module nirfd_queue
  import nirfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sym_class_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       nonempty_o,
  output sym_class_t pop_data_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sym_class_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `NIRFD_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `NIRFD_ASSERT_NEXT(a_cnt_grow, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1,
                     "queue count did not grow on push")

endmodule

FILE: hw/rtl/nirfd_front.sv
// ---------------------------------------------------------------------------
// NEC IR frame decoder front
// Holds the timing registers and classifies each accepted symbol.
// ---------------------------------------------------------------------------
module nirfd_front
  import nirfd_pkg::*;
#(
  parameter int TOLERANCE = DEF_TOLERANCE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 first_level_i,
  input  logic [DUR_W-1:0]     first_duration_i,
  input  logic                 second_level_i,
  input  logic [DUR_W-1:0]     second_duration_i,
  input  logic                 capture_end_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sym_class_t           q_data_o
);

  localparam logic [TOL_W-1:0] TOL = TOL_W'(TOLERANCE);
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  logic [DUR_W-1:0] regs_q [NUM_REGS];
  logic             lv_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[REG_IDX_W'(i)] <= cfg_reset_value(i);
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_idx_i[REG_IDX_W-1:0]] <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign lv_ok      = !first_level_i && second_level_i;

  always_comb begin
    q_data_o.hdr_ok  = lv_ok
                       && near_target(first_duration_i, regs_q[REG_IDX_W'(REG_HDR_MARK)], TOL)
                       && near_target(second_duration_i, regs_q[REG_IDX_W'(REG_HDR_SPACE)],
                                      TOL);
    q_data_o.one_ok  = lv_ok
                       && near_target(first_duration_i, regs_q[REG_IDX_W'(REG_ONE_MARK)], TOL)
                       && near_target(second_duration_i, regs_q[REG_IDX_W'(REG_ONE_SPACE)],
                                      TOL);
    q_data_o.zero_ok = lv_ok
                       && near_target(first_duration_i, regs_q[REG_IDX_W'(REG_ZRO_MARK)], TOL)
                       && near_target(second_duration_i, regs_q[REG_IDX_W'(REG_ZRO_SPACE)],
                                      TOL);
    q_data_o.ftr_ok  = lv_ok
                       && near_target(first_duration_i, regs_q[REG_IDX_W'(REG_FTR_MARK)], TOL)
                       && near_target(second_duration_i, regs_q[REG_IDX_W'(REG_FTR_SPACE)],
                                      TOL);
    q_data_o.last    = capture_end_i;
  end

endmodule

FILE: hw/rtl/nirfd_back.sv
// ---------------------------------------------------------------------------
// NEC IR frame decoder back
// Walks the frame state per symbol and registers the result item.
// ---------------------------------------------------------------------------
`include "nec_ir_frame_decoder_core_defines.svh"

module nirfd_back
  import nirfd_pkg::*;
#(
  parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_nonempty_i,
  input  sym_class_t         q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_valid_o,
  output logic [CODE_W-1:0]  decoded_code_o,
  output logic [COUNT_W-1:0] symbol_count_o
);

  localparam int IDX_W = $clog2(CAPTURE_DEPTH + 1);

  logic [IDX_W-1:0]   idx_q, idx_d, cnt_next;
  logic [CODE_W-1:0]  code_q, code_d, code_next;
  logic               bad_q, bad_d, bad_next;
  logic               sym_bad, is_data, emit, good;
  logic               out_valid_q;
  logic               frame_valid_q;
  logic [CODE_W-1:0]  code_out_q;
  logic [COUNT_W-1:0] count_q;

  assign q_pop_o = q_nonempty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    cnt_next = (idx_q < IDX_W'(CAPTURE_DEPTH)) ? idx_q + 1'b1 : idx_q;
    sym_bad  = 1'b0;
    is_data  = 1'b0;
    if (idx_q == '0) begin
      sym_bad = !q_data_i.hdr_ok;
    end else if (idx_q < IDX_W'(FOOTER_INDEX)) begin
      is_data = 1'b1;
      sym_bad = !q_data_i.one_ok && !q_data_i.zero_ok;
    end else if (idx_q == IDX_W'(FOOTER_INDEX)) begin
      sym_bad = !q_data_i.ftr_ok;
    end
    // data bits arrive MSB first: shift in a one when the one pattern matched
    code_next = is_data ? {code_q[CODE_W-2:0], q_data_i.one_ok} : code_q;
    bad_next  = bad_q || sym_bad;
    good      = !bad_next && (cnt_next >= IDX_W'(FRAME_SYMBOLS));
    emit      = q_pop_o && q_data_i.last && (cnt_next > IDX_W'(MIN_SYMBOLS));

    idx_d  = idx_q;
    code_d = code_q;
    bad_d  = bad_q;
    if (q_pop_o) begin
      if (q_data_i.last) begin
        idx_d  = '0;
        code_d = '0;
        bad_d  = 1'b0;
      end else begin
        idx_d  = cnt_next;
        code_d = code_next;
        bad_d  = bad_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      code_q      <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      code_q <= code_d;
      bad_q  <= bad_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_valid_q <= good;
      code_out_q    <= good ? code_next : '0;
      count_q       <= COUNT_W'(cnt_next);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_valid_o  = frame_valid_q;
  assign decoded_code_o = code_out_q;
  assign symbol_count_o = count_q;

  `NIRFD_ASSERT(a_idx_bound, idx_q <= IDX_W'(CAPTURE_DEPTH), "symbol index past capture depth")
  `NIRFD_ASSERT_NEXT(a_last_clears, q_pop_o && q_data_i.last, idx_q == '0 && !bad_q,
                     "frame state not cleared after capture end")
  `NIRFD_ASSERT(a_bad_zero_code, !(out_valid_q && !frame_valid_q) || code_out_q == '0,
                "invalid frame carries nonzero code")

endmodule

FILE: hw/rtl/nec_ir_frame_decoder_core.sv
// Result: the symbol that ends the capture passes through the queue to the back part,
// which registers out_valid_o once earlier symbols are out and the output is not stalled.
// Throughput: one symbol per cycle unless a stalled result item backs up the queue.
// Reset: asynchronous, active low; timing registers return to their defaults, the frame
// state, queue pointers and output valid clear at once, with no clearing pass.
// ---------------------------------------------------------------------------
// NEC IR frame decoder core
// Front classifies symbols against the timing targets, a two-entry queue
// decouples it from the back, which decodes the frame and emits results.
// ---------------------------------------------------------------------------
module nec_ir_frame_decoder_core
  import nirfd_pkg::*;
#(
  parameter int TOLERANCE     = DEF_TOLERANCE,
  parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 first_level_i,
  input  logic [DUR_W-1:0]     first_duration_i,
  input  logic                 second_level_i,
  input  logic [DUR_W-1:0]     second_duration_i,
  input  logic                 capture_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 frame_valid_o,
  output logic [CODE_W-1:0]    decoded_code_o,
  output logic [COUNT_W-1:0]   symbol_count_o
);

  logic       q_full, q_push, q_pop, q_nonempty;
  sym_class_t q_wdata, q_rdata;

  nirfd_front #(
    .TOLERANCE (TOLERANCE)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .first_level_i     (first_level_i),
    .first_duration_i  (first_duration_i),
    .second_level_i    (second_level_i),
    .second_duration_i (second_duration_i),
    .capture_end_i     (capture_end_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_wdata)
  );

  nirfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nonempty_o  (q_nonempty),
    .pop_data_o  (q_rdata)
  );

  nirfd_back #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_nonempty_i   (q_nonempty),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_valid_o  (frame_valid_o),
    .decoded_code_o (decoded_code_o),
    .symbol_count_o (symbol_count_o)
  );

endmodule

FILE: tb/tb_nec_ir_frame_decoder_core.sv
// ---------------------------------------------------------------------------
// NEC IR frame decoder core testbench
// Sends captures of IR symbols (well-formed frames, broken frames, short and
// overlong captures, noise) under several timing settings and idle patterns,
// predicts each decoded frame and checks every result item field by field.
// ---------------------------------------------------------------------------
module tb_nec_ir_frame_decoder_core;
  import nirfd_pkg::*;

  localparam int CLK_PERIOD        = 4;
  localparam int RESET_CYCLES      = 6;
  localparam int TOLERANCE         = DEF_TOLERANCE;
  localparam int CAPTURE_DEPTH     = DEF_CAPTURE_DEPTH;
  localparam int MAX_DUR           = 2**DUR_W - 1;
  localparam int REG_IDX_W         = $clog2(NUM_REGS);
  localparam int DIRECTED_ROWS     = 18;
  localparam int RANDOM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE   = 70;
  localparam int MIN_PHASE_RESULTS = 2;
  localparam int SETTLE_CYCLES     = 10;
  localparam int HOLD_CYCLES       = 200;
  localparam int MAX_REPORTS       = 10;
  localparam int RUN_LIMIT         = 4000000;

  typedef struct packed {
    logic             first_level;
    logic [DUR_W-1:0] first_dur;
    logic             second_level;
    logic [DUR_W-1:0] second_dur;
    logic             capture_end;
  } symbol_t;

  typedef struct packed {
    logic               frame_valid;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } frame_t;

  typedef enum int {BAD_FIRST_LEVEL, BAD_SECOND_LEVEL, BAD_DURATION} bad_e;
  typedef enum int {FILL_FRAME, FILL_EXTREMES, FILL_RANDOM} fill_e;
  typedef enum int {EXP_PREDICT, EXP_NONE, EXP_FRAME} exp_e;
  typedef enum int {CFG_DEFAULT, CFG_RANDOM, CFG_ALL_ZERO, CFG_ALL_MAX, CFG_MIXED} cfg_kind_e;
  typedef enum int {IDLE_RECV_HEAVY, IDLE_SEND_HEAVY, IDLE_NONE} idle_e;

  typedef struct {
    logic [CODE_W-1:0] code;
    int                nsym;
    int                bad_at;
    bad_e              bad_kind;
    bit                at_limit;
    fill_e             fill;
    exp_e              exp_kind;
    frame_t            exp_res;
  } capture_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DUR_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 first_level_i;
  logic [DUR_W-1:0]     first_duration_i;
  logic                 second_level_i;
  logic [DUR_W-1:0]     second_duration_i;
  logic                 capture_end_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 frame_valid_o;
  logic [CODE_W-1:0]    decoded_code_o;
  logic [COUNT_W-1:0]   symbol_count_o;

  // Timing targets as the block should hold them, and the frame state.
  logic [DUR_W-1:0]  targets [NUM_REGS];
  int                sym_count;
  logic [CODE_W-1:0] code_acc;
  bit                frame_bad;

  frame_t       frames_due[$];
  capture_row_t directed_plan [DIRECTED_ROWS];
  int           fail_count    = 0;
  int           items_sent    = 0;
  int           results_due   = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_off_req  = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  nec_ir_frame_decoder_core #(
    .TOLERANCE    (TOLERANCE),
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_level_i    (first_level_i),
    .first_duration_i (first_duration_i),
    .second_level_i   (second_level_i),
    .second_duration_i(second_duration_i),
    .capture_end_i    (capture_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_valid_o    (frame_valid_o),
    .decoded_code_o   (decoded_code_o),
    .symbol_count_o   (symbol_count_o)
  );

  function automatic logic [DUR_W-1:0] nec_default(input cfg_reg_e r);
    case (r)
      REG_HDR_MARK:  return DUR_W'(9000);
      REG_HDR_SPACE: return DUR_W'(4500);
      REG_ONE_SPACE: return DUR_W'(1690);
      REG_FTR_SPACE: return '0;
      default:       return DUR_W'(560);
    endcase
  endfunction

  // Signed window: a target below the tolerance has no lower bound.
  function automatic bit within_tol(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] t);
    int di;
    int ti;
    di = int'(d);
    ti = int'(t);
    return (di < ti + TOLERANCE) && (di > ti - TOLERANCE);
  endfunction

  function automatic bit fits(input symbol_t s, input cfg_reg_e mark_r,
                              input cfg_reg_e space_r);
    return !s.first_level && s.second_level
           && within_tol(s.first_dur, targets[REG_IDX_W'(mark_r)])
           && within_tol(s.second_dur, targets[REG_IDX_W'(space_r)]);
  endfunction

  // Advance the frame state by one symbol; return 1 when a frame is reported.
  function automatic bit decode_symbol(input symbol_t s, output frame_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (sym_count == 0) begin
      if (!fits(s, REG_HDR_MARK, REG_HDR_SPACE)) frame_bad = 1'b1;
    end else if (sym_count < FOOTER_INDEX) begin
      if (fits(s, REG_ONE_MARK, REG_ONE_SPACE)) code_acc[CODE_W - sym_count] = 1'b1;
      else if (!fits(s, REG_ZRO_MARK, REG_ZRO_SPACE)) frame_bad = 1'b1;
    end else if (sym_count == FOOTER_INDEX) begin
      if (!fits(s, REG_FTR_MARK, REG_FTR_SPACE)) frame_bad = 1'b1;
    end
    if (sym_count < CAPTURE_DEPTH) sym_count++;
    if (s.capture_end) begin
      if (sym_count > MIN_SYMBOLS) begin
        res.frame_valid = !frame_bad && (sym_count >= FRAME_SYMBOLS);
        res.code        = res.frame_valid ? code_acc : '0;
        res.count       = COUNT_W'(sym_count);
        hit             = 1'b1;
      end
      sym_count = 0;
      code_acc  = '0;
      frame_bad = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic [DUR_W-1:0] near_dur(input logic [DUR_W-1:0] t, input bit at_limit);
    int off;
    int d;
    if (at_limit) off = $urandom_range(1) ? TOLERANCE - 1 : 1 - TOLERANCE;
    else off = int'($urandom_range(2 * TOLERANCE - 2)) - (TOLERANCE - 1);
    d = int'(t) + off;
    if (d < 0) d = 0;
    if (d > MAX_DUR) d = MAX_DUR;
    return DUR_W'(d);
  endfunction

  function automatic symbol_t pair_symbol(input cfg_reg_e mark_r, input cfg_reg_e space_r,
                                          input bit at_limit);
    symbol_t s;
    s.first_level  = 1'b0;
    s.first_dur    = near_dur(targets[REG_IDX_W'(mark_r)], at_limit);
    s.second_level = 1'b1;
    s.second_dur   = near_dur(targets[REG_IDX_W'(space_r)], at_limit);
    s.capture_end  = 1'b0;
    return s;
  endfunction

  function automatic logic [DUR_W-1:0] any_dur();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return DUR_W'($urandom_range(MAX_DUR));
    endcase
  endfunction

  function automatic symbol_t noise_symbol();
    symbol_t s;
    s.first_level  = $urandom_range(1);
    s.first_dur    = any_dur();
    s.second_level = $urandom_range(1);
    s.second_dur   = any_dur();
    s.capture_end  = 1'b0;
    return s;
  endfunction

  function automatic symbol_t extreme_symbol(input int k);
    symbol_t s;
    s.first_level  = k[0];
    s.first_dur    = k[0] ? '1 : '0;
    s.second_level = k[1];
    s.second_dur   = k[1] ? '0 : '1;
    s.capture_end  = 1'b0;
    return s;
  endfunction

  task automatic send_symbol(input symbol_t s, input exp_e exp_kind, input frame_t exp_res);
    frame_t res;
    bit     hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    first_level_i     <= s.first_level;
    first_duration_i  <= s.first_dur;
    second_level_i    <= s.second_level;
    second_duration_i <= s.second_dur;
    capture_end_i     <= s.capture_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    hit = decode_symbol(s, res);
    case (exp_kind)
      EXP_PREDICT: if (hit) begin
        frames_due.push_back(res);
        results_due++;
      end
      EXP_FRAME: if (s.capture_end) begin
        frames_due.push_back(exp_res);
        results_due++;
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic run_capture(input capture_row_t row);
    symbol_t  s;
    cfg_reg_e mark_r;
    cfg_reg_e space_r;
    int       t;
    for (int i = 0; i < row.nsym; i++) begin
      if (row.fill == FILL_EXTREMES) begin
        s = extreme_symbol(i);
      end else if (row.fill == FILL_RANDOM || i > FOOTER_INDEX) begin
        s = noise_symbol();
      end else begin
        if (i == 0) begin
          mark_r  = REG_HDR_MARK;
          space_r = REG_HDR_SPACE;
        end else if (i < FOOTER_INDEX) begin
          mark_r  = row.code[CODE_W - i] ? REG_ONE_MARK : REG_ZRO_MARK;
          space_r = row.code[CODE_W - i] ? REG_ONE_SPACE : REG_ZRO_SPACE;
        end else begin
          mark_r  = REG_FTR_MARK;
          space_r = REG_FTR_SPACE;
        end
        s = pair_symbol(mark_r, space_r, row.at_limit);
        if (i == row.bad_at) begin
          case (row.bad_kind)
            BAD_FIRST_LEVEL:  s.first_level = 1'b1;
            BAD_SECOND_LEVEL: s.second_level = 1'b0;
            default: begin
              // push the mark just outside the window
              t = int'(targets[REG_IDX_W'(mark_r)]);
              s.first_dur = (t + TOLERANCE <= MAX_DUR) ? DUR_W'(t + TOLERANCE)
                                                       : DUR_W'(t - TOLERANCE);
            end
          endcase
        end
      end
      s.capture_end = (i == row.nsym - 1);
      send_symbol(s, row.exp_kind, row.exp_res);
    end
  endtask

  task automatic run_random_capture();
    capture_row_t row;
    int           pick;
    pick = $urandom_range(99);
    case ($urandom_range(15))
      0:       row.code = '0;
      1:       row.code = '1;
      default: row.code = $urandom();
    endcase
    row.at_limit = ($urandom_range(3) == 0);
    row.bad_kind = bad_e'($urandom_range(2));
    row.bad_at   = -1;
    row.exp_kind = EXP_PREDICT;
    row.exp_res  = '0;
    if (pick < 72) begin
      row.fill = FILL_FRAME;
      row.nsym = ($urandom_range(7) == 0) ? int'($urandom_range(80, 35)) : FRAME_SYMBOLS;
      if ($urandom_range(4) == 0) row.bad_at = $urandom_range(FOOTER_INDEX);
    end else if (pick < 88) begin
      row.fill = FILL_FRAME;
      row.nsym = $urandom_range(16, 1);
      if ($urandom_range(3) == 0) row.bad_at = $urandom_range(row.nsym - 1);
    end else begin
      row.fill = FILL_RANDOM;
      row.nsym = $urandom_range(40, 1);
    end
    run_capture(row);
  endtask

  task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx < NUM_REGS) targets[idx[REG_IDX_W-1:0]] = val;
    @(negedge clk_i);
  endtask

  task automatic load_timing(input cfg_kind_e kind);
    logic [DUR_W-1:0] v;
    for (int r = 0; r < NUM_REGS; r++) begin
      case (kind)
        CFG_DEFAULT:  v = nec_default(cfg_reg_e'(r));
        CFG_RANDOM:   v = DUR_W'($urandom_range(MAX_DUR));
        CFG_ALL_ZERO: v = '0;
        CFG_ALL_MAX:  v = '1;
        default:      v = $urandom_range(1) ? '1 : '0;
      endcase
      write_timing(CFG_IDX_W'(r), v);
    end
    // an index past the register file must leave every target alone
    write_timing(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NUM_REGS)), DUR_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every result, then let the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idling(input idle_e mode);
    case (mode)
      IDLE_RECV_HEAVY: begin
        send_idle_pct = 35;
        recv_idle_pct = 86;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 86;
        recv_idle_pct = 35;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  function automatic cfg_kind_e phase_timing(input int p);
    case (p)
      0:       return CFG_DEFAULT;
      2:       return CFG_ALL_ZERO;
      3:       return CFG_ALL_MAX;
      4:       return CFG_MIXED;
      default: return CFG_RANDOM;
    endcase
  endfunction

  initial begin : stimulus
    capture_row_t row;
    int           start_items;
    int           start_results;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    first_level_i     = 1'b0;
    first_duration_i  = '0;
    second_level_i    = 1'b0;
    second_duration_i = '0;
    capture_end_i     = 1'b0;
    for (int r = 0; r < NUM_REGS; r++) targets[REG_IDX_W'(r)] = nec_default(cfg_reg_e'(r));
    sym_count = 0;
    code_acc  = '0;
    frame_bad = 1'b0;

    // code, symbols, bad symbol, how it breaks, jitter at limit, fill, expectation, expected result
    directed_plan = '{
      '{32'hA5C3_0F01, 34, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b1, 32'hA5C3_0F01, 7'd34}},
      '{32'h0000_0000, 34, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b1, 32'h0000_0000, 7'd34}},
      '{32'hFFFF_FFFF, 34, -1, BAD_FIRST_LEVEL, 1'b1, FILL_FRAME, EXP_FRAME,
        '{1'b1, 32'hFFFF_FFFF, 7'd34}},
      '{32'h1234_5678, 1, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_NONE, '0},
      '{32'h1234_5678, 11, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_NONE, '0},
      '{32'h1234_5678, 12, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b0, 32'h0, 7'd12}},
      '{32'h1234_5678, 33, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b0, 32'h0, 7'd33}},
      '{32'h5555_AAAA, 34, 0, BAD_SECOND_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b0, 32'h0, 7'd34}},
      '{32'h5555_AAAA, 34, 1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b0, 32'h0, 7'd34}},
      '{32'h8000_0001, 34, 32, BAD_DURATION, 1'b1, FILL_FRAME, EXP_FRAME,
        '{1'b0, 32'h0, 7'd34}},
      '{32'h8000_0001, 34, 33, BAD_DURATION, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b0, 32'h0, 7'd34}},
      '{32'h0F0F_F0F0, 40, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b1, 32'h0F0F_F0F0, 7'd40}},
      '{32'h7E81_3C24, 64, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b1, 32'h7E81_3C24, 7'd64}},
      '{32'hDEAD_BEEF, 90, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_FRAME,
        '{1'b1, 32'hDEAD_BEEF, 7'd64}},
      '{32'h0, 14, -1, BAD_FIRST_LEVEL, 1'b0, FILL_EXTREMES, EXP_FRAME,
        '{1'b0, 32'h0, 7'd14}},
      '{32'h0, 1, -1, BAD_FIRST_LEVEL, 1'b0, FILL_EXTREMES, EXP_NONE, '0},
      '{32'h3C3C_5A5A, 34, 20, BAD_DURATION, 1'b0, FILL_FRAME, EXP_PREDICT, '0},
      '{32'h0, 20, -1, BAD_FIRST_LEVEL, 1'b0, FILL_RANDOM, EXP_PREDICT, '0}
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(IDLE_RECV_HEAVY);
    for (int k = 0; k < DIRECTED_ROWS; k++) run_capture(directed_plan[k]);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      set_idling(idle_e'(p / 2));
      load_timing(phase_timing(p));
      start_items   = items_sent;
      start_results = results_due;
      if (p == 4) begin
        // hold the output while short captures pile results into the block
        hold_off_req = 1'b1;
        row = '{32'h0, 12, -1, BAD_FIRST_LEVEL, 1'b0, FILL_FRAME, EXP_PREDICT, '0};
        repeat (6) run_capture(row);
      end
      while (items_sent - start_items < ITEMS_PER_PHASE ||
             results_due - start_results < MIN_PHASE_RESULTS) begin
        run_random_capture();
      end
    end
    settle();

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_t got;
    frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{frame_valid_o, decoded_code_o, symbol_count_o};
      if (frames_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result item: valid %0b code %h count %0d",
                   got.frame_valid, got.code, got.count);
      end else begin
        want = frames_due.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result mismatch: valid %0b/%0b code %h/%h count %0d/%0d (exp/act)",
                     want.frame_valid, got.frame_valid, want.code, got.code,
                     want.count, got.count);
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
